// ===== rtl/pcrg_pkg.sv =====
package pcrg_pkg;

  localparam int RES_W = 13;
  localparam int VP_W  = 22;
  localparam int POS_W = 32;
  localparam int DIR_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_W = 6 * POS_W;

  localparam int FRAC_SHIFT = 14;
  localparam int PART_W = 31;
  localparam int SQ_W   = 2 * PART_W + 2;
  localparam int LEN_W  = SQ_W / 2;
  localparam int NORM_NW = 62;
  localparam int NORM_QW = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_VP_HEIGHT    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_VP_WIDTH     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA_X     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA_Y     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA_Z     = 3'd6;

  localparam logic [RES_W-1:0] RST_IMAGE_WIDTH  = 13'd800;
  localparam logic [RES_W-1:0] RST_IMAGE_HEIGHT = 13'd600;
  localparam logic [VP_W-1:0]  RST_VP_HEIGHT    = 22'd131072;
  localparam logic [VP_W-1:0]  RST_VP_WIDTH     = 22'd174763;

endpackage

// ===== rtl/pinhole_camera_ray_generator.sv =====
// Channel  Direction  Fields (lowest bit first)
// s_*      in         pixel_x, pixel_y
// m_*      out        origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
// cfg_*    in         register index and write data
// One item enters per cycle while the output is not stalled.
// Most of the pipeline depth lies in the divider stages and the square root pipeline.
// Reset empties the pipeline and loads the default camera settings.
// A stalled output holds the whole pipeline, so nothing is lost or repeated.
module pinhole_camera_ray_generator #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata, // pixel_x, pixel_y
  output logic m_tvalid,
  input  logic m_tready,
  output logic [pcrg_pkg::OUT_W-1:0] m_tdata, // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic cfg_we,
  input  logic [pcrg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pcrg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcrg_pkg::*;

  localparam int MAGW   = (COORD_BITS + 1 > RES_W) ? COORD_BITS + 1 : RES_W;
  localparam int NUMW   = MAGW + 1;
  localparam int PRODW  = VP_W + MAGW;
  localparam int OFS_NW = PRODW + FRAC_SHIFT + 1;
  localparam int MW     = ((OFS_NW + 1) / 2) * 2;
  localparam int SW     = $clog2(MW - PART_W + 1);
  localparam int TAGW   = 2 + 3 * PART_W;

  logic [RES_W-1:0] image_width, image_height;
  logic [VP_W-1:0]  vp_height, vp_width;
  logic [POS_W-1:0] camera_x, camera_y, camera_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      vp_height    <= RST_VP_HEIGHT;
      vp_width     <= RST_VP_WIDTH;
      camera_x     <= '0;
      camera_y     <= '0;
      camera_z     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[RES_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[RES_W-1:0];
        CFG_VP_HEIGHT:    vp_height    <= cfg_data[VP_W-1:0];
        CFG_VP_WIDTH:     vp_width     <= cfg_data[VP_W-1:0];
        CFG_CAMERA_X:     camera_x     <= cfg_data;
        CFG_CAMERA_Y:     camera_y     <= cfg_data;
        CFG_CAMERA_Z:     camera_z     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [RES_W-1:0] wm1, hm1;
  assign wm1 = (image_width  < RES_W'(2)) ? RES_W'(1) : image_width  - RES_W'(1);
  assign hm1 = (image_height < RES_W'(2)) ? RES_W'(1) : image_height - RES_W'(1);

  logic [COORD_BITS-1:0] px, py;
  assign px = s_tdata[COORD_BITS-1:0];
  assign py = s_tdata[2*COORD_BITS-1:COORD_BITS];

  logic signed [NUMW-1:0] numx, numz;
  assign numx = $signed(NUMW'({px, 1'b0})) - $signed(NUMW'(wm1));
  assign numz = $signed(NUMW'(hm1)) - $signed(NUMW'({py, 1'b0}));

  logic            a_vld, a_negx, a_negz;
  logic [MAGW-1:0] a_magx, a_magz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_tvalid;
    end
    if (en) begin
      a_negx <= numx[NUMW-1];
      a_negz <= numz[NUMW-1];
      a_magx <= numx[NUMW-1] ? MAGW'(-numx) : MAGW'(numx);
      a_magz <= numz[NUMW-1] ? MAGW'(-numz) : MAGW'(numz);
    end
  end

  logic             b_vld, b_negx, b_negz;
  logic [PRODW-1:0] b_prodx, b_prodz;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
    if (en) begin
      b_negx  <= a_negx;
      b_negz  <= a_negz;
      b_prodx <= PRODW'(vp_width) * PRODW'(a_magx);
      b_prodz <= PRODW'(vp_height) * PRODW'(a_magz);
    end
  end

  logic [MW:0] ofs_numx, ofs_numz;
  assign ofs_numx = (MW+1)'({b_prodx, {FRAC_SHIFT{1'b0}}}) + (MW+1)'(wm1);
  assign ofs_numz = (MW+1)'({b_prodz, {FRAC_SHIFT{1'b0}}}) + (MW+1)'(hm1);

  logic          ofs_vld, ofs_negx, ofs_negz;
  logic [MW-1:0] ofs_qx, ofs_qz;

  pcrg_div_pipe #(
    .NW(MW + 1), .DW(RES_W + 1), .QW(MW), .STEPS(2), .TW(1)
  ) u_ofs_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(b_vld),
    .num(ofs_numx), .den({wm1, 1'b0}), .in_tag(b_negx),
    .out_valid(ofs_vld), .quo(ofs_qx), .out_tag(ofs_negx)
  );

  pcrg_div_pipe #(
    .NW(MW + 1), .DW(RES_W + 1), .QW(MW), .STEPS(2), .TW(1)
  ) u_ofs_z (
    .clk(clk), .rst(rst), .en(en), .in_valid(b_vld),
    .num(ofs_numz), .den({hm1, 1'b0}), .in_tag(b_negz),
    .out_valid(), .quo(ofs_qz), .out_tag(ofs_negz)
  );

  // The forward component is one, so only the side components can force a shift.
  logic [MW-1:0] ofs_or;
  logic [SW-1:0] shift_amt;
  assign ofs_or = ofs_qx | ofs_qz;

  always_comb begin
    shift_amt = '0;
    for (int i = PART_W; i < MW; i++) begin
      if (ofs_or[i]) begin
        shift_amt = SW'(i - PART_W + 1);
      end
    end
  end

  logic          c_vld, c_negx, c_negz;
  logic [MW-1:0] c_mx, c_mz;
  logic [SW-1:0] c_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= ofs_vld;
    end
    if (en) begin
      c_negx <= ofs_negx;
      c_negz <= ofs_negz;
      c_mx   <= ofs_qx;
      c_mz   <= ofs_qz;
      c_s    <= shift_amt;
    end
  end

  logic              d_vld, d_negx, d_negz;
  logic [PART_W-1:0] d_mx, d_my, d_mz;
  logic [MW-1:0]     mx_sh, mz_sh;
  logic [PART_W-1:0] my_sh;

  assign mx_sh = c_mx >> c_s;
  assign mz_sh = c_mz >> c_s;
  assign my_sh = (PART_W'(1) << (PART_W - 1)) >> c_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
    if (en) begin
      d_negx <= c_negx;
      d_negz <= c_negz;
      d_mx   <= mx_sh[PART_W-1:0];
      d_my   <= my_sh;
      d_mz   <= mz_sh[PART_W-1:0];
    end
  end

  logic                e_vld, e_negx, e_negz;
  logic [PART_W-1:0]   e_mx, e_my, e_mz;
  logic [2*PART_W-1:0] e_sqx, e_sqy, e_sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_vld;
    end
    if (en) begin
      e_negx <= d_negx;
      e_negz <= d_negz;
      e_mx   <= d_mx;
      e_my   <= d_my;
      e_mz   <= d_mz;
      e_sqx  <= (2*PART_W)'(d_mx) * (2*PART_W)'(d_mx);
      e_sqy  <= (2*PART_W)'(d_my) * (2*PART_W)'(d_my);
      e_sqz  <= (2*PART_W)'(d_mz) * (2*PART_W)'(d_mz);
    end
  end

  logic            f_vld;
  logic [TAGW-1:0] f_tag;
  logic [SQ_W-1:0] f_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
    if (en) begin
      f_tag <= {e_negx, e_negz, e_mx, e_my, e_mz};
      f_sum <= SQ_W'(e_sqx) + SQ_W'(e_sqy) + SQ_W'(e_sqz);
    end
  end

  logic              sq_vld;
  logic [LEN_W-1:0]  len;
  logic [TAGW-1:0]   sq_tag;

  pcrg_sqrt_pipe #(.STEPS(2), .TW(TAGW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_vld),
    .radicand(f_sum), .in_tag(f_tag),
    .out_valid(sq_vld), .root(len), .out_tag(sq_tag)
  );

  logic              sq_negx, sq_negz;
  logic [PART_W-1:0] sq_mx, sq_my, sq_mz;
  assign {sq_negx, sq_negz, sq_mx, sq_my, sq_mz} = sq_tag;

  logic [NORM_NW-1:0] nrm_numx, nrm_numy, nrm_numz, half_len;
  assign half_len = NORM_NW'(len >> 1);
  assign nrm_numx = NORM_NW'({sq_mx, 30'd0}) + half_len;
  assign nrm_numy = NORM_NW'({sq_my, 30'd0}) + half_len;
  assign nrm_numz = NORM_NW'({sq_mz, 30'd0}) + half_len;

  logic               nrm_vld, nrm_negx, nrm_negz;
  logic [NORM_QW-1:0] nrm_qx, nrm_qy, nrm_qz;

  pcrg_div_pipe #(
    .NW(NORM_NW), .DW(LEN_W), .QW(NORM_QW), .STEPS(2), .TW(1)
  ) u_nrm_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq_vld),
    .num(nrm_numx), .den(len), .in_tag(sq_negx),
    .out_valid(nrm_vld), .quo(nrm_qx), .out_tag(nrm_negx)
  );

  pcrg_div_pipe #(
    .NW(NORM_NW), .DW(LEN_W), .QW(NORM_QW), .STEPS(2), .TW(1)
  ) u_nrm_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq_vld),
    .num(nrm_numy), .den(len), .in_tag(1'b0),
    .out_valid(), .quo(nrm_qy), .out_tag()
  );

  pcrg_div_pipe #(
    .NW(NORM_NW), .DW(LEN_W), .QW(NORM_QW), .STEPS(2), .TW(1)
  ) u_nrm_z (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq_vld),
    .num(nrm_numz), .den(len), .in_tag(sq_negz),
    .out_valid(), .quo(nrm_qz), .out_tag(nrm_negz)
  );

  logic [DIR_W-1:0] dir_x, dir_y, dir_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= nrm_vld;
    end
    if (en) begin
      dir_x <= nrm_negx ? DIR_W'(32'd0 - nrm_qx) : DIR_W'(nrm_qx);
      dir_y <= DIR_W'(nrm_qy);
      dir_z <= nrm_negz ? DIR_W'(32'd0 - nrm_qz) : DIR_W'(nrm_qz);
    end
  end

  assign m_tdata = {dir_z, dir_y, dir_x, camera_z, camera_y, camera_x};

`ifndef ASSERT_OFF
  localparam logic signed [DIR_W-1:0] DIR_ONE = 32'sh4000_0000;

  a_fwd_positive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(dir_y) > 0 && $signed(dir_y) <= DIR_ONE))
    else $error("forward component out of range");

  a_dir_x_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(dir_x) <= DIR_ONE && $signed(dir_x) >= -DIR_ONE))
    else $error("dir_x out of range");

  a_dir_z_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(dir_z) <= DIR_ONE && $signed(dir_z) >= -DIR_ONE))
    else $error("dir_z out of range");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result present straight after reset");
`endif

endmodule

// ===== rtl/pcrg_div_pipe.sv =====
module pcrg_div_pipe #(
  parameter int NW    = 51,
  parameter int DW    = 14,
  parameter int QW    = 50,
  parameter int STEPS = 2,
  parameter int TW    = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] out_tag
);

  localparam int STAGES = QW / STEPS;

  logic [STAGES:0] vld;
  logic [DW-1:0]   rem  [STAGES+1];
  logic [QW-1:0]   sh   [STAGES+1];
  logic [DW-1:0]   dv   [STAGES+1];
  logic [TW-1:0]   tag  [STAGES+1];

  assign vld[0] = in_valid;
  assign rem[0] = DW'(num[NW-1:QW]);
  assign sh[0]  = num[QW-1:0];
  assign dv[0]  = den;
  assign tag[0] = in_tag;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [DW-1:0] rem_next;
    logic [QW-1:0] sh_next;

    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [QW-1:0] s;
      logic          qb;
      r = rem[g];
      s = sh[g];
      for (int k = 0; k < STEPS; k++) begin
        t = {r, s[QW-1]};
        if (t >= {1'b0, dv[g]}) begin
          r  = DW'(t - {1'b0, dv[g]});
          qb = 1'b1;
        end else begin
          r  = t[DW-1:0];
          qb = 1'b0;
        end
        s = {s[QW-2:0], qb};
      end
      rem_next = r;
      sh_next  = s;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        rem[g+1] <= rem_next;
        sh[g+1]  <= sh_next;
        dv[g+1]  <= dv[g];
        tag[g+1] <= tag[g];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign quo       = sh[STAGES];
  assign out_tag   = tag[STAGES];

endmodule

// ===== rtl/pcrg_sqrt_pipe.sv =====
module pcrg_sqrt_pipe #(
  parameter int STEPS = 2,
  parameter int TW    = 95
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [pcrg_pkg::SQ_W-1:0] radicand,
  input  logic [TW-1:0]             in_tag,
  output logic                      out_valid,
  output logic [pcrg_pkg::LEN_W-1:0] root,
  output logic [TW-1:0]             out_tag
);
  import pcrg_pkg::*;

  localparam int STAGES = LEN_W / STEPS;
  localparam int RW = LEN_W + 2;

  logic [STAGES:0]   vld;
  logic [RW-1:0]     rem [STAGES+1];
  logic [LEN_W-1:0]  rt  [STAGES+1];
  logic [SQ_W-1:0]   rad [STAGES+1];
  logic [TW-1:0]     tag [STAGES+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign rad[0] = radicand;
  assign tag[0] = in_tag;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [RW-1:0]    rem_next;
    logic [LEN_W-1:0] rt_next;
    logic [SQ_W-1:0]  rad_next;

    always_comb begin
      logic [RW-1:0]    t;
      logic [RW-1:0]    trial;
      logic [LEN_W-1:0] q;
      logic [SQ_W-1:0]  n;
      t = rem[g];
      q = rt[g];
      n = rad[g];
      for (int k = 0; k < STEPS; k++) begin
        t     = {t[LEN_W-1:0], n[SQ_W-1:SQ_W-2]};
        trial = {q, 2'b01};
        if (t >= trial) begin
          t = t - trial;
          q = {q[LEN_W-2:0], 1'b1};
        end else begin
          q = {q[LEN_W-2:0], 1'b0};
        end
        n = {n[SQ_W-3:0], 2'b00};
      end
      rem_next = t;
      rt_next  = q;
      rad_next = n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        rem[g+1] <= rem_next;
        rt[g+1]  <= rt_next;
        rad[g+1] <= rad_next;
        tag[g+1] <= tag[g];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign root      = rt[STAGES];
  assign out_tag   = tag[STAGES];

endmodule
